### design/klst_pkg.sv
// ----------------------------------------------------------------------------
// klst_pkg
// shared types and constants of the keyed latency statistics table
// ----------------------------------------------------------------------------
package klst_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [15:0] PERIOD_RESET   = 16'd5;
    localparam logic [15:0] IDLE_RESET     = 16'd600;

    // millisecond divide: (ns >> 6) / 15625 as a multiply by the rounded-up
    // reciprocal 2^72 / 15625, exact for every 58-bit dividend
    localparam logic [58:0] MS_RECIP       = 59'd302231454903657294;
    localparam int          DIV_STEPS      = 4;

    // configuration register indexes
    localparam logic CFG_REPORT_PERIOD = 1'b0;
    localparam logic CFG_IDLE_LIMIT    = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_STORED = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] count;
        logic [47:0] sum;
        logic [47:0] peak;
        logic [31:0] seen;
        logic [31:0] rtime;
    } klst_row_t;

    typedef struct packed {
        logic load;
        logic idx_inc;
        logic rd_idx;
        logic rd_slot;
        logic cmp;
        logic evt_upd;
        logic evt_full;
        logic scan_proc;
        logic scan_done;
    } klst_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic cur_valid;
        logic found;
        logic has_free;
        logic div_done;
        logic mode;
    } klst_sts_t;

endpackage

### design/klst_ctrl.sv
// ----------------------------------------------------------------------------
// klst_ctrl
// sequencer for event lookup and table scan
// ----------------------------------------------------------------------------
module klst_ctrl
    import klst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  klst_sts_t sts,
    output klst_cmd_t cmd,
    output logic      busy
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_S_RD   = 8'b0000_0010,
        ST_S_CMP  = 8'b0000_0100,
        ST_S_END  = 8'b0000_1000,
        ST_E_WAIT = 8'b0001_0000,
        ST_C_CHK  = 8'b0010_0000,
        ST_C_PROC = 8'b0100_0000,
        ST_C_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.mode ? ST_C_CHK : ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_S_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_S_RD;
                end
            end
            ST_S_END:
            begin
                if (sts.found)
                begin
                    cmd.rd_slot = 1'b1;
                    state_next  = ST_E_WAIT;
                end
                else if (sts.has_free)
                begin
                    state_next = ST_E_WAIT;
                end
                else
                begin
                    cmd.evt_full = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_E_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.evt_upd = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_C_CHK:
            begin
                if (sts.cur_valid)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = ST_C_PROC;
                end
                else if (sts.idx_last)
                begin
                    state_next = ST_C_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_C_PROC:
            begin
                cmd.scan_proc = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_C_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_C_CHK;
                end
            end
            ST_C_DONE:
            begin
                cmd.scan_done = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### design/klst_dp.sv
// ----------------------------------------------------------------------------
// klst_dp
// entry memory, valid bits, duration divider and result registers
// ----------------------------------------------------------------------------
module klst_dp
    import klst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  klst_cmd_t   cmd,
    output klst_sts_t   sts,
    input  logic        mode,
    input  logic [31:0] proc_id,
    input  logic [63:0] start_ns,
    input  logic [63:0] end_ns,
    input  logic [31:0] now_secs,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [31:0] rec_proc_id,
    output logic [31:0] event_count,
    output logic [47:0] latency_sum_ms,
    output logic [47:0] latency_max_ms,
    output logic        last
);

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);

    klst_row_t mem [TABLE_DEPTH];
    klst_row_t rd_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [15:0] period_reg, idle_reg;
    logic [IDX_W-1:0] idx_reg, slot_reg, free_reg;
    logic found_reg, has_free_reg;
    logic [31:0] id_reg, now_reg;

    // reciprocal multiply state, one 29x30 partial product per cycle
    logic [57:0]  dvd_reg;
    logic [116:0] acc_reg;
    logic [2:0]   cnt_reg;

    logic        res_valid_reg;
    logic [1:0]  res_kind_reg;
    logic [31:0] res_id_reg, res_cnt_reg;
    logic [47:0] res_sum_reg, res_max_reg;
    logic        res_last_reg;

    logic [63:0]  diff;
    logic [28:0]  mul_a;
    logic [29:0]  mul_b;
    logic [58:0]  mul_p;
    logic [116:0] mul_sh;
    logic [47:0]  quo;

    assign diff  = end_ns - start_ns;
    assign mul_a = cnt_reg[1] ? dvd_reg[57:29] : dvd_reg[28:0];
    assign mul_b = cnt_reg[0] ? {1'b0, MS_RECIP[58:30]} : MS_RECIP[29:0];
    assign mul_p = 59'(mul_a) * 59'(mul_b);
    assign quo   = {3'd0, acc_reg[116:72]};

    // place the partial product at its weight
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    mul_sh = {58'd0, mul_p};
            2'd1:    mul_sh = {28'd0, mul_p, 30'd0};
            2'd2:    mul_sh = {29'd0, mul_p, 29'd0};
            default: mul_sh = {mul_p[57:0], 59'd0};
        endcase
    end

    // event update
    klst_row_t   base_row, evt_row;
    logic [48:0] sum_ext;
    logic [IDX_W-1:0] evt_slot;

    always_comb
    begin
        base_row       = found_reg ? rd_reg : '0;
        evt_slot       = found_reg ? slot_reg : free_reg;
        evt_row        = base_row;
        evt_row.key    = id_reg;
        evt_row.seen   = now_reg;
        if (base_row.count != 32'hFFFF_FFFF)
        begin
            evt_row.count = base_row.count + 32'd1;
        end
        sum_ext     = {1'b0, base_row.sum} + {1'b0, quo};
        evt_row.sum = sum_ext[48] ? 48'hFFFF_FFFF_FFFF : sum_ext[47:0];
        if (quo > base_row.peak)
        begin
            evt_row.peak = quo;
        end
    end

    // scan update
    klst_row_t scan_row;
    logic      due, idle_out;

    always_comb
    begin
        scan_row = rd_reg;
        due      = 1'b0;
        if ((rd_reg.rtime == 32'd0) || (now_reg < rd_reg.rtime))
        begin
            scan_row.rtime = now_reg;
        end
        else if ((now_reg > rd_reg.rtime)
                 && ((now_reg - rd_reg.rtime) >= {16'd0, period_reg}))
        begin
            scan_row.rtime = now_reg;
            due            = 1'b1;
        end
        if (due)
        begin
            scan_row.count = '0;
            scan_row.sum   = '0;
            scan_row.peak  = '0;
        end
        idle_out = (now_reg > rd_reg.seen)
                   && ((now_reg - rd_reg.seen) >= {16'd0, idle_reg});
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.evt_upd)
        begin
            mem[evt_slot] <= evt_row;
        end
        else if (cmd.scan_proc)
        begin
            mem[idx_reg] <= scan_row;
        end
        if (cmd.rd_idx)
        begin
            rd_reg <= mem[idx_reg];
        end
        else if (cmd.rd_slot)
        begin
            rd_reg <= mem[slot_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            period_reg    <= PERIOD_RESET;
            idle_reg      <= IDLE_RESET;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            has_free_reg  <= 1'b0;
            cnt_reg       <= 3'(DIV_STEPS);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_REPORT_PERIOD: period_reg <= cfg_data;
                    CFG_IDLE_LIMIT:    idle_reg   <= cfg_data;
                    default:           period_reg <= period_reg;
                endcase
            end
            if (cmd.load)
            begin
                idx_reg      <= '0;
                found_reg    <= 1'b0;
                has_free_reg <= 1'b0;
                cnt_reg      <= '0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (cnt_reg != 3'(DIV_STEPS))
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
            if (cmd.cmp)
            begin
                if (!found_reg && valid_reg[idx_reg] && (rd_reg.key == id_reg))
                begin
                    found_reg <= 1'b1;
                end
                if (!has_free_reg && !valid_reg[idx_reg])
                begin
                    has_free_reg <= 1'b1;
                end
            end
            if (cmd.evt_upd)
            begin
                valid_reg[evt_slot] <= 1'b1;
            end
            if (cmd.scan_proc && idle_out)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
            res_valid_reg <= cmd.evt_upd | cmd.evt_full | cmd.scan_done
                             | (cmd.scan_proc & due);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg  <= proc_id;
            now_reg <= now_secs;
            dvd_reg <= (end_ns > start_ns) ? diff[63:6] : 58'd0;
            acc_reg <= '0;
        end
        else if (cnt_reg != 3'(DIV_STEPS))
        begin
            acc_reg <= acc_reg + mul_sh;
        end
        if (cmd.cmp)
        begin
            if (!found_reg && valid_reg[idx_reg] && (rd_reg.key == id_reg))
            begin
                slot_reg <= idx_reg;
            end
            if (!has_free_reg && !valid_reg[idx_reg])
            begin
                free_reg <= idx_reg;
            end
        end
        if (cmd.evt_upd)
        begin
            res_kind_reg <= KIND_STORED;
            res_id_reg   <= id_reg;
            res_cnt_reg  <= evt_row.count;
            res_sum_reg  <= evt_row.sum;
            res_max_reg  <= evt_row.peak;
            res_last_reg <= 1'b1;
        end
        else if (cmd.evt_full)
        begin
            res_kind_reg <= KIND_FULL;
            res_id_reg   <= id_reg;
            res_cnt_reg  <= '0;
            res_sum_reg  <= '0;
            res_max_reg  <= '0;
            res_last_reg <= 1'b1;
        end
        else if (cmd.scan_proc)
        begin
            res_kind_reg <= KIND_REPORT;
            res_id_reg   <= rd_reg.key;
            res_cnt_reg  <= rd_reg.count;
            res_sum_reg  <= rd_reg.sum;
            res_max_reg  <= rd_reg.peak;
            res_last_reg <= 1'b0;
        end
        else if (cmd.scan_done)
        begin
            res_kind_reg <= KIND_DONE;
            res_id_reg   <= '0;
            res_cnt_reg  <= '0;
            res_sum_reg  <= '0;
            res_max_reg  <= '0;
            res_last_reg <= 1'b1;
        end
    end

    assign sts.idx_last  = (idx_reg == IDX_MAX);
    assign sts.cur_valid = valid_reg[idx_reg];
    assign sts.found     = found_reg;
    assign sts.has_free  = has_free_reg;
    assign sts.div_done  = (cnt_reg == 3'(DIV_STEPS));
    assign sts.mode      = mode;

    assign result_valid   = res_valid_reg;
    assign kind           = res_kind_reg;
    assign rec_proc_id    = res_id_reg;
    assign event_count    = res_cnt_reg;
    assign latency_sum_ms = res_sum_reg;
    assign latency_max_ms = res_max_reg;
    assign last           = res_last_reg;

endmodule

### design/keyed_latency_stats_table.sv
// ----------------------------------------------------------------------------
// keyed_latency_stats_table
// per-process latency statistics table with periodic report scan
// ----------------------------------------------------------------------------
// channel   signals                                        handshake
// input     mode proc_id start_ns end_ns now_secs          start && !busy
// result    kind rec_proc_id event_count latency_*_ms last  result_valid, 1 cycle
// config    cfg_idx cfg_data                                cfg_we
//
// an event item walks the table entry by entry (memory read, key compare),
// overlapped with a four-step reciprocal multiply for the millisecond divide
// a scan item checks every entry, reads and updates each valid one, then
// gives the done item; the single-port entry memory serializes these steps
// reset clears the valid bits and the control registers; no clearing pass
// results cannot be stalled: each is on the ports for one cycle
// ----------------------------------------------------------------------------
module keyed_latency_stats_table
    import klst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] proc_id,
    input  logic [63:0] start_ns,
    input  logic [63:0] end_ns,
    input  logic [31:0] now_secs,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [31:0] rec_proc_id,
    output logic [31:0] event_count,
    output logic [47:0] latency_sum_ms,
    output logic [47:0] latency_max_ms,
    output logic        last
);

    klst_cmd_t cmd;
    klst_sts_t sts;

    // sequencer
    klst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // table, divider and result registers
    klst_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (mode),
        .proc_id        (proc_id),
        .start_ns       (start_ns),
        .end_ns         (end_ns),
        .now_secs       (now_secs),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .kind           (kind),
        .rec_proc_id    (rec_proc_id),
        .event_count    (event_count),
        .latency_sum_ms (latency_sum_ms),
        .latency_max_ms (latency_max_ms),
        .last           (last)
    );

endmodule

### design/klst_checker.sv
// ----------------------------------------------------------------------------
// klst_checker
// port level checks of the statistics table
// ----------------------------------------------------------------------------
module klst_checker
    import klst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [1:0]  kind,
    input logic [31:0] rec_proc_id,
    input logic [31:0] event_count,
    input logic        last
);

    // final item comes with the block idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("last result while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !result_valid)
        else $error("result without an item");

    a_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> kind == KIND_REPORT)
        else $error("non-final result that is not a report");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_DONE |-> last && rec_proc_id == 32'd0
            && event_count == 32'd0)
        else $error("scan done result malformed");

endmodule

bind keyed_latency_stats_table klst_checker u_klst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .rec_proc_id  (rec_proc_id),
    .event_count  (event_count),
    .last         (last)
);

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the keyed latency statistics table against a behavioral table model:
// directed corner items, then random event/scan traffic with bursty start
// ----------------------------------------------------------------------------
module tb;
    import klst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_SCAN  = 1'b1;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] MS_MAX  = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic        mode;
        logic [31:0] pid;
        logic [63:0] t0;
        logic [63:0] t1;
        logic [31:0] now;
    } item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] pid;
        logic [31:0] cnt;
        logic [47:0] sum;
        logic [47:0] peak;
        logic        last;
    } rec_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [31:0] proc_id;
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic [31:0] now_secs;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic [1:0]  kind;
    logic [31:0] rec_proc_id;
    logic [31:0] event_count;
    logic [47:0] latency_sum_ms;
    logic [47:0] latency_max_ms;
    logic        last;

    keyed_latency_stats_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .proc_id(proc_id), .start_ns(start_ns), .end_ns(end_ns),
        .now_secs(now_secs), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .result_valid(result_valid), .kind(kind),
        .rec_proc_id(rec_proc_id), .event_count(event_count),
        .latency_sum_ms(latency_sum_ms), .latency_max_ms(latency_max_ms),
        .last(last)
    );

    // shadow copy of the process table
    logic        tbl_valid [TABLE_DEPTH];
    logic [31:0] tbl_key   [TABLE_DEPTH];
    logic [31:0] tbl_cnt   [TABLE_DEPTH];
    logic [47:0] tbl_sum   [TABLE_DEPTH];
    logic [47:0] tbl_peak  [TABLE_DEPTH];
    logic [31:0] tbl_seen  [TABLE_DEPTH];
    logic [31:0] tbl_rtime [TABLE_DEPTH];
    logic [15:0] period_reg;
    logic [15:0] idle_reg;

    item_t pending_items[$];
    rec_t  expected_recs[$];
    int    error_count;
    int    gap_left;
    int    burst_left;
    bit    hold_off;

    // live process ids so random events hit existing entries
    logic [31:0] pid_pool[$];

    function automatic rec_t make_rec(logic [1:0] k, logic [31:0] p, logic [31:0] c,
                                      logic [47:0] s, logic [47:0] m, logic l);
        rec_t r;
        r.kind = k; r.pid = p; r.cnt = c; r.sum = s; r.peak = m; r.last = l;
        return r;
    endfunction

    // update the table for one accepted item and queue its records
    task automatic predict_table(item_t it);
        int slot;
        logic [63:0] dur;
        logic [48:0] acc;
        bit due;
        slot = -1;
        if (it.mode == MODE_EVENT) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot < 0 && tbl_valid[i] && tbl_key[i] == it.pid) slot = i;
            if (slot < 0) begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (slot < 0 && !tbl_valid[i]) slot = i;
                if (slot < 0) begin
                    expected_recs.push_back(make_rec(KIND_FULL, it.pid, '0, '0, '0, 1'b1));
                    return;
                end
                tbl_valid[slot] = 1'b1;
                tbl_key[slot]   = it.pid;
                tbl_cnt[slot]   = '0;
                tbl_sum[slot]   = '0;
                tbl_peak[slot]  = '0;
                tbl_rtime[slot] = '0;
            end
            tbl_seen[slot] = it.now;
            if (tbl_cnt[slot] != CNT_MAX) tbl_cnt[slot]++;
            if (it.t1 > it.t0) begin
                dur = (it.t1 - it.t0) / 64'd1000000;
                acc = {1'b0, tbl_sum[slot]} + dur[48:0];
                // duration can exceed 48 bits only above 2^48 ms
                tbl_sum[slot] = (acc > {1'b0, MS_MAX} || dur > {16'd0, MS_MAX}) ?
                                MS_MAX : acc[47:0];
                if (dur > {16'd0, tbl_peak[slot]}) tbl_peak[slot] = dur[47:0];
            end
            expected_recs.push_back(make_rec(KIND_STORED, it.pid, tbl_cnt[slot],
                                             tbl_sum[slot], tbl_peak[slot], 1'b1));
        end
        else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (tbl_valid[i]) begin
                    due = 0;
                    if (tbl_rtime[i] == 0 || it.now < tbl_rtime[i])
                        tbl_rtime[i] = it.now;
                    else if (it.now > tbl_rtime[i] &&
                             it.now - tbl_rtime[i] >= {16'd0, period_reg}) begin
                        tbl_rtime[i] = it.now;
                        due = 1;
                    end
                    if (due) begin
                        expected_recs.push_back(make_rec(KIND_REPORT, tbl_key[i],
                            tbl_cnt[i], tbl_sum[i], tbl_peak[i], 1'b0));
                        tbl_cnt[i] = '0; tbl_sum[i] = '0; tbl_peak[i] = '0;
                    end
                    if (it.now > tbl_seen[i] && it.now - tbl_seen[i] >= {16'd0, idle_reg})
                        tbl_valid[i] = 1'b0;
                end
            end
            expected_recs.push_back(make_rec(KIND_DONE, '0, '0, '0, '0, 1'b1));
        end
    endtask

    function automatic item_t mk_item(logic m, logic [31:0] p, logic [63:0] a,
                                      logic [63:0] b, logic [31:0] n);
        item_t it;
        it.mode = m; it.pid = p; it.t0 = a; it.t1 = b; it.now = n;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver: start raised at the falling edge, held until accepted
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (start && busy) begin
                // keep holding the current item
            end
            else if (gap_left > 0 || hold_off || pending_items.size() == 0) begin
                start <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
            else begin
                item_t it;
                it = pending_items.pop_front();
                start    <= 1'b1;
                mode     <= it.mode;
                proc_id  <= it.pid;
                start_ns <= it.t0;
                end_ns   <= it.t1;
                now_secs <= it.now;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 8);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // monitor: acceptance feeds the predictor, results are checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                predict_table(mk_item(mode, proc_id, start_ns, end_ns, now_secs));
            if (result_valid) begin
                if (expected_recs.size() == 0) begin
                    $error("unexpected result kind=%0d pid=%h", kind, rec_proc_id);
                    error_count++;
                end
                else begin
                    rec_t e;
                    e = expected_recs.pop_front();
                    if (kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, kind); error_count++;
                    end
                    if (rec_proc_id !== e.pid) begin
                        $error("rec_proc_id exp %h got %h", e.pid, rec_proc_id);
                        error_count++;
                    end
                    if (event_count !== e.cnt) begin
                        $error("event_count exp %0d got %0d", e.cnt, event_count);
                        error_count++;
                    end
                    if (latency_sum_ms !== e.sum) begin
                        $error("latency_sum_ms exp %0d got %0d", e.sum, latency_sum_ms);
                        error_count++;
                    end
                    if (latency_max_ms !== e.peak) begin
                        $error("latency_max_ms exp %0d got %0d", e.peak, latency_max_ms);
                        error_count++;
                    end
                    if (last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, last); error_count++;
                    end
                end
            end
        end
    end

    // wait until every queued item went in and every result came out
    task automatic drain();
        while (pending_items.size() != 0 || start || expected_recs.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_REPORT_PERIOD) period_reg = val; else idle_reg = val;
    endtask

    function automatic logic [31:0] pick_pid();
        if (pid_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return pid_pool[$urandom_range(0, pid_pool.size() - 1)];
        return $urandom();
    endfunction

    // one random phase; now advances mostly slowly so reports and idling happen
    task automatic random_phase(int n, int npids);
        logic [31:0] clock_s;
        logic [63:0] a;
        clock_s = $urandom_range(1, 1000);
        pid_pool.delete();
        for (int i = 0; i < npids; i++) pid_pool.push_back($urandom());
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: clock_s = clock_s - $urandom_range(0, 20);
                1: clock_s = $urandom();
                default: clock_s = clock_s + $urandom_range(0, 8);
            endcase
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(mk_item(MODE_SCAN, $urandom(), rand64(),
                                                rand64(), clock_s));
            else begin
                a = rand64();
                case ($urandom_range(0, 4))
                    0: pending_items.push_back(mk_item(MODE_EVENT, pick_pid(), a,
                                                       rand64(), clock_s));
                    1: pending_items.push_back(mk_item(MODE_EVENT, pick_pid(), a,
                                                       a - $urandom(), clock_s));
                    default: pending_items.push_back(mk_item(MODE_EVENT, pick_pid(), a,
                        a + {$urandom_range(0, 3), $urandom()}, clock_s));
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0; start = 1'b0; mode = 1'b0; proc_id = '0; start_ns = '0;
        end_ns = '0; now_secs = '0; cfg_we = 1'b0; cfg_idx = CFG_REPORT_PERIOD;
        cfg_data = '0; error_count = 0; gap_left = 0; burst_left = 0;
        hold_off = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
        period_reg = PERIOD_RESET; idle_reg = IDLE_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: first scan arms timers, extremes of times and ids
        pending_items.push_back(mk_item(MODE_SCAN, '0, '0, '0, 32'd0));
        pending_items.push_back(mk_item(MODE_EVENT, 32'd0, '0, '1, 32'd10));
        pending_items.push_back(mk_item(MODE_EVENT, 32'd0, 64'd5, 64'd5, 32'd10));
        pending_items.push_back(mk_item(MODE_EVENT, CNT_MAX, '1, '0, '1));
        pending_items.push_back(mk_item(MODE_EVENT, CNT_MAX, 64'd0, 64'd999999, '1));
        pending_items.push_back(mk_item(MODE_EVENT, 32'h5555_AAAA, 64'd0,
                                        64'd1000000, 32'h8000_0000));
        pending_items.push_back(mk_item(MODE_SCAN, '1, '1, '1, 32'd100));
        pending_items.push_back(mk_item(MODE_SCAN, '0, '0, '0, 32'd104));
        pending_items.push_back(mk_item(MODE_SCAN, '0, '0, '0, 32'd105));
        // now earlier than the report time restamps it
        pending_items.push_back(mk_item(MODE_SCAN, '0, '0, '0, 32'd50));
        pending_items.push_back(mk_item(MODE_SCAN, '0, '0, '0, '1));
        drain();

        // fill the table past full, then a burst of long durations on one entry
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            pending_items.push_back(mk_item(MODE_EVENT, 32'h1000 + i, '0, '1, 32'd7));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(mk_item(MODE_EVENT, 32'h1000, '0, '1, 32'd7));
        pending_items.push_back(mk_item(MODE_SCAN, '0, '0, '0, 32'd7));
        pending_items.push_back(mk_item(MODE_SCAN, '0, '0, '0, 32'd700));
        drain();

        // phases across register settings, extremes included
        write_cfg(CFG_REPORT_PERIOD, 16'd0);
        write_cfg(CFG_IDLE_LIMIT, 16'd1);
        random_phase(60, 12);
        drain();
        write_cfg(CFG_REPORT_PERIOD, 16'hFFFF);
        write_cfg(CFG_IDLE_LIMIT, 16'hFFFF);
        random_phase(60, 40);
        // let part of the phase go in, then pause until everything is back
        repeat (1500) @(posedge clk);
        hold_off = 1'b1;
        while (start || expected_recs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        hold_off = 1'b0;
        drain();
        write_cfg(CFG_REPORT_PERIOD, 16'd3);
        write_cfg(CFG_IDLE_LIMIT, 16'd20);
        random_phase(90, 20);
        drain();
        write_cfg(CFG_REPORT_PERIOD, 16'($urandom_range(1, 10)));
        write_cfg(CFG_IDLE_LIMIT, 16'd0);
        random_phase(50, 10);
        drain();
        write_cfg(CFG_REPORT_PERIOD, 16'($urandom()));
        write_cfg(CFG_IDLE_LIMIT, 16'($urandom_range(1, 50)));
        random_phase(100, 30);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog: ~410 items plus their gaps, with a wide margin
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
